// ===== hw/rtl/bmap_pkg.sv =====
// Shared types and constants for the bitmap allocator with first-clear search.
// Used by bmap_store, bmap_scan and bitmap_allocator_find_first_clear_top.
package bmap_pkg;

  localparam int NUM_BITS = 1024;
  localparam int IDX_W    = 10;                 // bit_index and result index width
  localparam int SIZE_W   = 11;                 // size_in_use register width
  localparam int WORD_W   = 32;                 // bits per store word
  localparam int BIT_W    = $clog2(WORD_W);     // bit position within a word
  localparam int NUM_WORDS = NUM_BITS / WORD_W;
  localparam int WADDR_W  = $clog2(NUM_WORDS);

  localparam int IN_FIELDS_W  = 2 + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + 1 + IDX_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int PADDR_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(NUM_BITS);

  // Operation codes.
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_FIND  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;

  // Register index decoded from paddr.
  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } store_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;      // stored bits, one set bit per allocated entry
    logic [BIT_W-1:0]  start;     // lowest position searched
    logic              is_last;   // word holds the last bit in use
    logic [BIT_W-1:0]  lim;       // highest position in use when is_last
  } scan_req_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

endpackage

// ===== hw/rtl/bmap_store.sv =====
// Word-organized bitmap store with registered read and per-word valid bits.
// Depends on bmap_pkg; a word that was never written reads as all zeros.
module bmap_store (
  input  logic                        clk,
  input  logic                        rst,
  input  bmap_pkg::store_req_t        req,
  output logic [bmap_pkg::WORD_W-1:0] rd_word
);
  import bmap_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid;
  logic [WORD_W-1:0]    rd_data;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  // Valid bits stand in for clearing the whole store at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= valid[req.rd_addr];
      end
    end
  end

  assign rd_word = rd_ok ? rd_data : '0;

endmodule

// ===== hw/rtl/bmap_scan.sv =====
// Find-first-clear unit over one store word, shared by every search step.
// Depends on bmap_pkg for the request and result structs.
module bmap_scan (
  input  bmap_pkg::scan_req_t req,
  output bmap_pkg::scan_res_t res
);
  import bmap_pkg::*;

  logic [WORD_W-1:0] cand;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      cand[i] = !req.word[i] && (BIT_W'(i) >= req.start) &&
                (!req.is_last || (BIT_W'(i) <= req.lim));
    end
  end

  // Walk from the top so the lowest candidate wins.
  always_comb begin
    res.hit = |cand;
    res.pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.pos = BIT_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/bitmap_allocator_find_first_clear_top.sv =====
// Top level of the bitmap allocator: APB register, stream ports and sequencer.
// Depends on bmap_pkg, bmap_store and bmap_scan.
//
//   port group   dir  width  beat contents
//   s_*          in   16     mode, bit_index
//   m_*          out  16     status, bit_value, first_free
//   APB          in   32     size_in_use at address 0
//
// An index out of range goes straight from S_IDLE to S_DONE; set, clear and read
// pass through S_RD and S_EVAL first. A search repeats S_RD (one read) and S_EVAL
// (one scan) for each store word visited, bounded by the word count of the size in
// use. Reset is synchronous; the store reads as all zeros after reset with no
// clearing pass. A beat held by m_tready low stops the next result in S_DONE, and
// s_tready stays low while that result waits there.
module bitmap_allocator_find_first_clear_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmap_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bmap_pkg::IN_TDATA_W-1:0]   s_tdata,   // mode[1:0], bit_index[11:2]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bmap_pkg::OUT_TDATA_W-1:0]  m_tdata    // status[1:0], bit_value[2],
                                                       // first_free[12:3]
);
  import bmap_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EVAL, S_DONE} state_t;

  state_t             state;
  logic [SIZE_W-1:0]  size_in_use;
  logic [1:0]         op;
  logic [IDX_W-1:0]   idx;
  logic [WADDR_W-1:0] cur_word;
  logic [1:0]         res_status;
  logic               res_value;
  logic [IDX_W-1:0]   res_found;
  logic [1:0]         out_status;
  logic               out_value;
  logic [IDX_W-1:0]   out_found;

  logic [SIZE_W-1:0]  live_size;
  logic [SIZE_W-1:0]  last_pos;
  logic [WADDR_W-1:0] last_word;
  logic [1:0]         in_mode;
  logic [IDX_W-1:0]   in_idx;
  logic               in_bad;
  logic               cfg_wr;
  logic [WORD_W-1:0]  rd_word;
  store_req_t         store_req;
  scan_req_t          scan_req;
  scan_res_t          scan_res;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_wr && (paddr[2] == REG_SIZE_IN_USE)) begin
      size_in_use <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? {{(32 - SIZE_W){1'b0}}, size_in_use} : '0;

  assign live_size = (size_in_use > SIZE_MAX) ? SIZE_MAX : size_in_use;
  assign last_pos  = live_size - 1'b1;
  assign last_word = last_pos[IDX_W-1:BIT_W];

  assign in_mode  = s_tdata[1:0];
  assign in_idx   = s_tdata[IDX_W+1:2];
  assign in_bad   = {1'b0, in_idx} >= live_size;
  assign s_tready = (state == S_IDLE);

  // Store access and search unit.
  always_comb begin
    store_req.rd_en   = (state == S_RD);
    store_req.rd_addr = cur_word;
    store_req.wr_en   = (state == S_EVAL) && ((op == MODE_SET) || (op == MODE_CLEAR));
    store_req.wr_addr = cur_word;
    store_req.wr_data = rd_word;
    store_req.wr_data[idx[BIT_W-1:0]] = (op == MODE_SET);
  end

  bmap_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_word (rd_word)
  );

  always_comb begin
    scan_req.word    = rd_word;
    scan_req.start   = (cur_word == idx[IDX_W-1:BIT_W]) ? idx[BIT_W-1:0] : '0;
    scan_req.is_last = (cur_word == last_word);
    scan_req.lim     = last_pos[BIT_W-1:0];
  end

  bmap_scan u_scan (
    .req (scan_req),
    .res (scan_res)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // In S_DONE the result load below decides m_tvalid on its own.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= in_mode;
            idx        <= in_idx;
            cur_word   <= in_idx[IDX_W-1:BIT_W];
            res_status <= in_bad ? ST_BAD_INDEX : ST_OK;
            res_value  <= 1'b0;
            res_found  <= '0;
            state      <= in_bad ? S_DONE : S_RD;
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (op)
            MODE_READ: begin
              res_value <= rd_word[idx[BIT_W-1:0]];
              state     <= S_DONE;
            end
            MODE_FIND: begin
              if (scan_res.hit) begin
                res_found <= {cur_word, scan_res.pos};
                state     <= S_DONE;
              end else if (scan_req.is_last) begin
                res_status <= ST_NO_SPACE;
                state      <= S_DONE;
              end else begin
                cur_word <= cur_word + 1'b1;
                state    <= S_RD;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_status <= res_status;
            out_value  <= res_value;
            out_found  <= res_found;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_found, out_value, out_status};

  // A failed request reports no bit value and no index.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[IDX_W+2:3] == '0) && !m_tdata[2])
    else $error("failed result carries data");

  // The search never walks past the last word in use.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) && (op == MODE_FIND) |-> cur_word <= last_word)
    else $error("search beyond size in use");

  // An accepted beat either goes straight to the result or starts a store read.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == S_RD) || (state == S_DONE))
    else $error("sequencer did not start on accepted beat");

  // A result loaded for a search found below the start index is impossible.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) && (op == MODE_FIND) && scan_res.hit |->
      {cur_word, scan_res.pos} >= idx)
    else $error("search hit below start index");

endmodule
